// File: src/sdq_pkg.sv
// ----------------------------------------------------------------------------
// sdq_pkg: shared types and constants of the sorted destination queue
// Item layouts, request codes, controller states, the per-cell command and
// the saturation helpers used on the result side.
// ----------------------------------------------------------------------------
package sdq_pkg;

    localparam int ENTRIES  = 16;
    localparam int FLOOR_W  = 6;
    localparam int WEIGHT_W = 12;
    localparam int SUM_OUT_W = 16;
    localparam int CNT_OUT_W = 5;
    // Stored count runs from zero to ENTRIES inclusive.
    localparam int CNT_W = $clog2(ENTRIES + 1);
    // Exact total of all stored weights never overflows this width.
    localparam int SUM_W = $clog2(ENTRIES * ((1 << WEIGHT_W) - 1) + 1);

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_QUERY  = 2'd2,
        REQ_CLEAR  = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]          req_type;
        logic [FLOOR_W-1:0]  dest_floor;
        logic [WEIGHT_W-1:0] load_weight;
    } t_in_item;

    typedef struct packed {
        logic                 status;
        logic                 floor_present;
        logic [SUM_OUT_W-1:0] removed_weight;
        logic [CNT_OUT_W-1:0] removed_count;
        logic [FLOOR_W-1:0]   next_stop;
        logic                 queue_empty;
        logic [CNT_OUT_W-1:0] entry_count;
        logic [SUM_OUT_W-1:0] total_weight;
    } t_out_item;

    // Command broadcast to every cell of the row.
    typedef struct packed {
        logic                ins_en;
        logic                rem_en;
        logic [FLOOR_W-1:0]  key_floor;
        logic [WEIGHT_W-1:0] new_weight;
    } t_cell_cmd;

    function automatic logic [CNT_OUT_W-1:0] sat_count(input logic [CNT_W-1:0] c);
        logic [CNT_W+CNT_OUT_W-1:0] wide;
        wide = {{CNT_OUT_W{1'b0}}, c};
        if (wide > (CNT_W + CNT_OUT_W)'((1 << CNT_OUT_W) - 1)) begin
            return {CNT_OUT_W{1'b1}};
        end
        return wide[CNT_OUT_W-1:0];
    endfunction

    function automatic logic [SUM_OUT_W-1:0] sat_sum(input logic [SUM_W-1:0] s);
        logic [SUM_W+SUM_OUT_W-1:0] wide;
        wide = {{SUM_OUT_W{1'b0}}, s};
        if (wide > (SUM_W + SUM_OUT_W)'((1 << SUM_OUT_W) - 1)) begin
            return {SUM_OUT_W{1'b1}};
        end
        return wide[SUM_OUT_W-1:0];
    endfunction

endpackage

// File: src/sdq_cell.sv
// ----------------------------------------------------------------------------
// sdq_cell: one slot of the sorted entry row
// Holds one (floor, weight) entry, compares it against the broadcast key and
// takes its left or right neighbor's entry when the row shifts.
// ----------------------------------------------------------------------------
module sdq_cell (
    input  logic                             i_clk,
    input  sdq_pkg::t_cell_cmd               i_cmd,
    input  logic                             i_occupied,
    input  logic                             i_left_stay,
    input  logic [sdq_pkg::FLOOR_W-1:0]      i_left_floor,
    input  logic [sdq_pkg::WEIGHT_W-1:0]     i_left_weight,
    input  logic [sdq_pkg::FLOOR_W-1:0]      i_right_floor,
    input  logic [sdq_pkg::WEIGHT_W-1:0]     i_right_weight,
    output logic [sdq_pkg::FLOOR_W-1:0]      o_floor,
    output logic [sdq_pkg::WEIGHT_W-1:0]     o_weight,
    output logic                             o_stay,
    output logic                             o_match
);

    logic [sdq_pkg::FLOOR_W-1:0]  r_floor;
    logic [sdq_pkg::WEIGHT_W-1:0] r_weight;
    logic [sdq_pkg::FLOOR_W-1:0]  n_floor;
    logic [sdq_pkg::WEIGHT_W-1:0] n_weight;
    logic                         at_or_after;

    // An entry stays put on insert when its floor is not above the key, so a
    // new entry lands after all entries of the same floor.
    assign o_stay      = i_occupied && (r_floor <= i_cmd.key_floor);
    assign o_match     = i_occupied && (r_floor == i_cmd.key_floor);
    assign at_or_after = !i_occupied || (r_floor >= i_cmd.key_floor);

    always_comb begin
        n_floor  = r_floor;
        n_weight = r_weight;
        if (i_cmd.ins_en && !o_stay) begin
            if (i_left_stay) begin
                n_floor  = i_cmd.key_floor;
                n_weight = i_cmd.new_weight;
            end else begin
                n_floor  = i_left_floor;
                n_weight = i_left_weight;
            end
        end else if (i_cmd.rem_en && at_or_after) begin
            n_floor  = i_right_floor;
            n_weight = i_right_weight;
        end
    end

    always_ff @(posedge i_clk) begin
        r_floor  <= n_floor;
        r_weight <= n_weight;
    end

    assign o_floor  = r_floor;
    assign o_weight = r_weight;

endmodule

// File: src/sorted_destination_queue_core.sv
// ----------------------------------------------------------------------------
// sorted_destination_queue_core: floor-ordered destination table
// A row of cells keeps (floor, weight) entries in ascending floor order and
// serves insert, remove-floor, query-floor and clear requests.
// ----------------------------------------------------------------------------
// Usage:
// An item is presented on i_item with start high and is taken at a clock edge
// where busy is low. The block then works on it and returns exactly one result
// on o_result, marked by o_result_valid for a single cycle; the receiver cannot
// hold the result off and must capture it in that cycle.
// For insert, query and clear, the whole cell row shifts or is searched in
// parallel in the execute state, and the result cycle follows directly. A
// remove stays in the execute state while the row shifts left by one place
// per cycle until no entry of that floor is left, then gives its result.
// busy is low during the result cycle, so a new item can be taken there.
// Reset clears the entry count and the running total weight; the cell
// contents are not cleared and are never read above the entry count.
// Every result reports the lowest stored floor, the entry count and the
// total weight as they stand after the request.
// ----------------------------------------------------------------------------
module sorted_destination_queue_core (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  sdq_pkg::t_in_item      i_item,
    output logic                   o_result_valid,
    output sdq_pkg::t_out_item     o_result
);

    localparam int N = sdq_pkg::ENTRIES;

    sdq_pkg::t_state              r_state;
    sdq_pkg::t_state              n_state;
    sdq_pkg::t_req                r_req;
    logic [sdq_pkg::FLOOR_W-1:0]  r_floor;
    logic [sdq_pkg::WEIGHT_W-1:0] r_weight;
    logic [sdq_pkg::CNT_W-1:0]    r_count;
    logic [sdq_pkg::CNT_W-1:0]    n_count;
    logic [sdq_pkg::SUM_W-1:0]    r_total;
    logic [sdq_pkg::SUM_W-1:0]    n_total;
    logic [sdq_pkg::SUM_OUT_W-1:0] r_rem_w;
    logic [sdq_pkg::SUM_OUT_W-1:0] n_rem_w;
    logic [sdq_pkg::CNT_W-1:0]    r_rem_c;
    logic [sdq_pkg::CNT_W-1:0]    n_rem_c;
    logic                         r_status;
    logic                         n_status;
    logic                         r_present;
    logic                         n_present;

    logic                         accept;
    logic                         exec;
    logic                         full;
    logic                         any_match;
    logic                         step_done;
    logic [sdq_pkg::WEIGHT_W-1:0] sel_weight;
    logic [sdq_pkg::SUM_OUT_W:0]  rem_sum;
    sdq_pkg::t_cell_cmd           cmd;

    logic [N-1:0]                 occ;
    logic [N-1:0]                 stay;
    logic [N-1:0]                 match;
    logic [sdq_pkg::FLOOR_W-1:0]  cell_floor  [N];
    logic [sdq_pkg::WEIGHT_W-1:0] cell_weight [N];

    assign accept = start && !busy;
    assign full   = (r_count == sdq_pkg::CNT_W'(N));

    // ------------------------------------------------------------------
    // Cell row. Occupancy is a thermometer code derived from the count.
    // ------------------------------------------------------------------
    always_comb begin
        for (int i = 0; i < N; i++) begin
            occ[i] = (sdq_pkg::CNT_W'(i) < r_count);
        end
    end

    assign cmd.ins_en     = exec && (r_req == sdq_pkg::REQ_INSERT) && !full;
    assign cmd.rem_en     = exec && (r_req == sdq_pkg::REQ_REMOVE) && any_match;
    assign cmd.key_floor  = r_floor;
    assign cmd.new_weight = r_weight;

    for (genvar g = 0; g < N; g++) begin : g_cell
        logic                         left_stay;
        logic [sdq_pkg::FLOOR_W-1:0]  left_floor;
        logic [sdq_pkg::WEIGHT_W-1:0] left_weight;
        logic [sdq_pkg::FLOOR_W-1:0]  right_floor;
        logic [sdq_pkg::WEIGHT_W-1:0] right_weight;

        // The first cell is the insert point when its own entry moves; the
        // last cell pulls in its own contents, which fall above the count.
        if (g == 0) begin : g_head
            assign left_stay   = 1'b1;
            assign left_floor  = cell_floor[g];
            assign left_weight = cell_weight[g];
        end else begin : g_body
            assign left_stay   = stay[g-1];
            assign left_floor  = cell_floor[g-1];
            assign left_weight = cell_weight[g-1];
        end
        if (g == N - 1) begin : g_tail
            assign right_floor  = cell_floor[g];
            assign right_weight = cell_weight[g];
        end else begin : g_mid
            assign right_floor  = cell_floor[g+1];
            assign right_weight = cell_weight[g+1];
        end

        sdq_cell u_cell (
            .i_clk          (i_clk),
            .i_cmd          (cmd),
            .i_occupied     (occ[g]),
            .i_left_stay    (left_stay),
            .i_left_floor   (left_floor),
            .i_left_weight  (left_weight),
            .i_right_floor  (right_floor),
            .i_right_weight (right_weight),
            .o_floor        (cell_floor[g]),
            .o_weight       (cell_weight[g]),
            .o_stay         (stay[g]),
            .o_match        (match[g])
        );
    end

    // Entries of one floor sit next to each other, so the entry that leaves
    // on a remove step is the first matching cell of the row.
    always_comb begin
        sel_weight = '0;
        for (int i = 0; i < N; i++) begin
            if (match[i] && ((i == 0) || !match[(i == 0) ? 0 : i - 1])) begin
                sel_weight = sel_weight | cell_weight[i];
            end
        end
    end

    assign any_match = |match;
    assign rem_sum   = {1'b0, r_rem_w} + (sdq_pkg::SUM_OUT_W + 1)'(sel_weight);

    // A remove keeps working while a matching entry remains; every other
    // request completes in its first execute cycle.
    assign step_done = !((r_req == sdq_pkg::REQ_REMOVE) && any_match);

    // ------------------------------------------------------------------
    // Controller: next state.
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            sdq_pkg::ST_IDLE: begin
                if (accept) begin
                    n_state = sdq_pkg::ST_EXEC;
                end
            end
            sdq_pkg::ST_EXEC: begin
                if (step_done) begin
                    n_state = sdq_pkg::ST_DONE;
                end
            end
            sdq_pkg::ST_DONE: begin
                n_state = accept ? sdq_pkg::ST_EXEC : sdq_pkg::ST_IDLE;
            end
            default: begin
                n_state = sdq_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Controller: outputs.
    // ------------------------------------------------------------------
    always_comb begin
        busy           = 1'b0;
        exec           = 1'b0;
        o_result_valid = 1'b0;
        case (r_state)
            sdq_pkg::ST_IDLE: begin
            end
            sdq_pkg::ST_EXEC: begin
                busy = 1'b1;
                exec = 1'b1;
            end
            sdq_pkg::ST_DONE: begin
                o_result_valid = 1'b1;
            end
            default: begin
                busy = 1'b1;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Count, total and per-item outcome.
    // ------------------------------------------------------------------
    always_comb begin
        n_count   = r_count;
        n_total   = r_total;
        n_rem_w   = r_rem_w;
        n_rem_c   = r_rem_c;
        n_status  = r_status;
        n_present = r_present;
        if (accept) begin
            n_rem_w   = '0;
            n_rem_c   = '0;
            n_status  = 1'b0;
            n_present = 1'b0;
        end else if (exec) begin
            case (r_req)
                sdq_pkg::REQ_INSERT: begin
                    if (full) begin
                        n_status = 1'b1;
                    end else begin
                        n_count = r_count + 1'b1;
                        n_total = r_total + sdq_pkg::SUM_W'(r_weight);
                    end
                end
                sdq_pkg::REQ_REMOVE: begin
                    if (any_match) begin
                        n_count = r_count - 1'b1;
                        n_total = r_total - sdq_pkg::SUM_W'(sel_weight);
                        n_rem_c = r_rem_c + 1'b1;
                        n_rem_w = rem_sum[sdq_pkg::SUM_OUT_W] ? '1
                                  : rem_sum[sdq_pkg::SUM_OUT_W-1:0];
                    end
                end
                sdq_pkg::REQ_QUERY: begin
                    n_present = any_match;
                end
                sdq_pkg::REQ_CLEAR: begin
                    n_count = '0;
                    n_total = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sdq_pkg::ST_IDLE;
            r_count <= '0;
            r_total <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_total <= n_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req    <= sdq_pkg::t_req'(i_item.req_type);
            r_floor  <= i_item.dest_floor;
            r_weight <= i_item.load_weight;
        end
        r_rem_w   <= n_rem_w;
        r_rem_c   <= n_rem_c;
        r_status  <= n_status;
        r_present <= n_present;
    end

    // ------------------------------------------------------------------
    // Result fields, all taken from registers.
    // ------------------------------------------------------------------
    always_comb begin
        o_result.status         = r_status;
        o_result.floor_present  = r_present;
        o_result.removed_weight = r_rem_w;
        o_result.removed_count  = sdq_pkg::sat_count(r_rem_c);
        o_result.next_stop      = occ[0] ? cell_floor[0] : '0;
        o_result.queue_empty    = !occ[0];
        o_result.entry_count    = sdq_pkg::sat_count(r_count);
        o_result.total_weight   = sdq_pkg::sat_sum(r_total);
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= sdq_pkg::CNT_W'(N))
        else $error("entry count above table size");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("accepted item did not start execution");

    a_empty_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result.queue_empty) |-> (o_result.total_weight == '0))
        else $error("empty table reports a nonzero total weight");

    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result.status) |-> (full && (r_rem_c == '0)))
        else $error("dropped insert reported while table not full");
`endif

endmodule
